### hw/rtl/zone_status_frame_deframer_core_defines.svh
// ----------------------------------------------------------------------------
// Zone status deframer assertion macros
// Shared concurrent assertion forms used by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef ZONE_STATUS_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define ZONE_STATUS_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ZSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ZSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/zsd_pkg.sv
// ----------------------------------------------------------------------------
// Zone status deframer package
// Shared constants, event codes and types for the status frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package zsd_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int FRAME_BYTES        = 8;
    localparam int ZONES              = 6;
    localparam int GAP_W              = 16;

    localparam logic [7:0]       START_BYTE    = 8'h08;
    localparam logic [7:0]       LOW7          = 8'h7F;
    localparam logic [7:0]       TOP_BIT       = 8'h80;
    localparam logic [7:0]       ECHO_FIRST    = 8'hC0;
    localparam logic [7:0]       ECHO_SECOND   = 8'h30;
    localparam logic [7:0]       ECHO_MAX_MASK = 8'h20;
    localparam logic [GAP_W-1:0] GAP_RESET     = 16'd20;

    // Result event codes
    typedef enum logic [1:0] {
        EV_GOOD    = 2'd0,
        EV_BAD     = 2'd1,
        EV_TIMEOUT = 2'd2
    } event_t;

    // Eight collected bytes, byte 0 is the start byte
    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    // Frame check outcome
    typedef struct packed {
        logic             good;
        logic [ZONES-1:0] mask;
        logic [2:0]       slide_fill;
    } check_t;

endpackage

`default_nettype wire

### hw/rtl/zone_status_frame_deframer_core.sv
// Results: an input transfer is held in the input register, and its result
//   then goes to the result register, which a stalled m_ready can hold.
// Throughput: one item per cycle unless m_ready stalls a held result; the
//   frame check is a single combinational pass from input to result register.
// Reset: synchronous active-low aresetn clears prefix, fill, mask and counters,
//   and loads gap_ticks with 20. No clearing pass; s_ready is high on release.
`default_nettype none

`include "zone_status_frame_deframer_core_defines.svh"

module zone_status_frame_deframer_core
    import zsd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_mode,
    input  wire logic [7:0]        s_rx_byte,
    // Result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_event_res,
    output logic [ZONES-1:0]       m_zone_mask,
    output logic                   m_mask_changed,
    output logic [31:0]            m_good_frames,
    output logic [31:0]            m_bad_frames,
    // Configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [GAP_W-1:0]  cfg_gap_ticks
);

    typedef enum logic [1:0] {
        PFX_IDLE,
        PFX_C0,
        PFX_30
    } pfx_t;

    // Control state
    pfx_t                  pfx_reg, pfx_next;
    logic [2:0]            fill_reg, fill_next;
    logic [ZONES-1:0]      known_reg, known_next;
    logic                  seen_reg, seen_next;
    logic [COUNT_BITS-1:0] good_reg, good_next;
    logic [COUNT_BITS-1:0] bad_reg, bad_next;
    logic [GAP_W-1:0]      idle_reg, idle_next;
    logic [GAP_W-1:0]      gap_reg;
    logic                  in_valid_reg;
    logic                  m_valid_reg;

    // Payload
    logic                  in_mode_reg;
    logic [7:0]            in_byte_reg;
    frame_t                frame_reg;
    event_t                ev_reg;
    logic [ZONES-1:0]      mask_reg;
    logic                  changed_reg;
    logic [31:0]           good_out_reg;
    logic [31:0]           bad_out_reg;

    logic                  advance;
    logic                  shift_en;
    logic                  res_valid;
    event_t                res_ev;
    logic [ZONES-1:0]      res_mask;
    logic                  res_changed;
    logic                  mask_ok;
    logic [GAP_W-1:0]      idle_inc;
    frame_t                check_frame;
    check_t                check;

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Echo mask byte: zero or a single bit up to 0x20
    assign mask_ok = (in_byte_reg == 8'h00) || (in_byte_reg == 8'h01) ||
                     (in_byte_reg == 8'h02) || (in_byte_reg == 8'h04) ||
                     (in_byte_reg == START_BYTE) || (in_byte_reg == 8'h10) ||
                     (in_byte_reg == ECHO_MAX_MASK);

    // Frame as it stands once the current byte is appended
    always_comb begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            check_frame[i] = frame_reg[i+1];
        end
        check_frame[FRAME_BYTES-1] = in_byte_reg;
    end

    zsd_frame_check u_check (
        .frame  (check_frame),
        .result (check)
    );

    // Per-item step
    always_comb begin
        logic take;
        pfx_next    = pfx_reg;
        fill_next   = fill_reg;
        known_next  = known_reg;
        seen_next   = seen_reg;
        good_next   = good_reg;
        bad_next    = bad_reg;
        idle_next   = idle_reg;
        shift_en    = 1'b0;
        res_valid   = 1'b0;
        res_ev      = EV_GOOD;
        res_mask    = known_reg;
        res_changed = 1'b0;
        take        = 1'b0;
        idle_inc    = (idle_reg < gap_reg) ? idle_reg + GAP_W'(1) : idle_reg;

        if (advance) begin
            if (in_mode_reg) begin
                // Tick: idle gap drops prefix and any partial frame
                idle_next = idle_inc;
                if (idle_inc >= gap_reg) begin
                    pfx_next = PFX_IDLE;
                    if (fill_reg != 3'd0) begin
                        fill_next = 3'd0;
                        bad_next  = bad_reg + COUNT_BITS'(1);
                        res_valid = 1'b1;
                        res_ev    = EV_TIMEOUT;
                    end
                end
            end else begin
                idle_next = '0;
                take      = 1'b1;
                // Between frames: swallow the command echo
                if (fill_reg == 3'd0) begin
                    take = 1'b0;
                    if (in_byte_reg == ECHO_FIRST) begin
                        pfx_next = PFX_C0;
                    end else if (pfx_reg == PFX_C0 && in_byte_reg == ECHO_SECOND) begin
                        pfx_next = PFX_30;
                    end else begin
                        pfx_next = PFX_IDLE;
                        if (!(pfx_reg == PFX_30 && mask_ok)) begin
                            take = (in_byte_reg == START_BYTE);
                        end
                    end
                end
                if (take) begin
                    shift_en = 1'b1;
                    if (fill_reg == 3'(FRAME_BYTES - 1)) begin
                        res_valid = 1'b1;
                        if (check.good) begin
                            res_ev      = EV_GOOD;
                            res_mask    = check.mask;
                            res_changed = !seen_reg || (known_reg != check.mask);
                            good_next   = good_reg + COUNT_BITS'(1);
                            known_next  = check.mask;
                            seen_next   = 1'b1;
                            fill_next   = 3'd0;
                        end else begin
                            res_ev    = EV_BAD;
                            bad_next  = bad_reg + COUNT_BITS'(1);
                            fill_next = check.slide_fill;
                        end
                    end else begin
                        fill_next = fill_reg + 3'd1;
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pfx_reg      <= PFX_IDLE;
            fill_reg     <= '0;
            known_reg    <= '0;
            seen_reg     <= 1'b0;
            good_reg     <= '0;
            bad_reg      <= '0;
            idle_reg     <= '0;
            gap_reg      <= GAP_RESET;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pfx_reg   <= pfx_next;
            fill_reg  <= fill_next;
            known_reg <= known_next;
            seen_reg  <= seen_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
            idle_reg  <= idle_next;
            if (cfg_valid && cfg_ready) begin
                gap_reg <= cfg_gap_ticks;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_byte_reg <= s_rx_byte;
        end
        if (shift_en) begin
            frame_reg <= check_frame;
        end
        if (advance && res_valid) begin
            ev_reg       <= res_ev;
            mask_reg     <= res_mask;
            changed_reg  <= res_changed;
            good_out_reg <= 32'(good_next);
            bad_out_reg  <= 32'(bad_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_res    = ev_reg;
    assign m_zone_mask    = mask_reg;
    assign m_mask_changed = changed_reg;
    assign m_good_frames  = good_out_reg;
    assign m_bad_frames   = bad_out_reg;

    // Checks
    `ZSD_ASSERT_NOW(a_ready_low_only_when_full, aclk, aresetn, !s_ready,
        in_valid_reg && m_valid_reg && !m_ready, "input stalled without a full pipe")
    `ZSD_ASSERT_NOW(a_no_prefix_in_frame, aclk, aresetn, fill_reg != 3'd0,
        pfx_reg == PFX_IDLE, "echo prefix progress while a frame is held")
    `ZSD_ASSERT_NEXT(a_byte_clears_idle, aclk, aresetn, advance && !in_mode_reg,
        idle_reg == '0, "received byte did not clear the idle count")
    `ZSD_ASSERT_NEXT(a_good_updates_mask, aclk, aresetn,
        advance && res_valid && res_ev == EV_GOOD,
        seen_reg && known_reg == m_zone_mask && m_valid, "valid status not recorded")
    `ZSD_ASSERT_NEXT(a_result_posted, aclk, aresetn, advance && res_valid,
        m_valid, "result lost on the way to the output register")

endmodule

`default_nettype wire

### hw/rtl/zsd_frame_check.sv
// ----------------------------------------------------------------------------
// Zone status frame check
// Validates a complete 8-byte status frame, extracts the zone mask and finds
// the refill level for sliding to the next start byte after a rejection.
// ----------------------------------------------------------------------------
`default_nettype none

module zsd_frame_check
    import zsd_pkg::*;
(
    input  frame_t frame,
    output check_t result
);

    always_comb begin
        logic [7:0] sum;
        logic       fmt_ok;
        logic       slid;
        sum                = frame[0];
        fmt_ok             = (frame[0] == START_BYTE);
        result.mask        = '0;
        result.slide_fill  = '0;
        slid               = 1'b0;

        // Index bytes: low seven bits count up, top bit is the zone flag
        for (int k = 0; k < ZONES; k++) begin
            if ((frame[k+1] & LOW7) != 8'(k)) begin
                fmt_ok = 1'b0;
            end
            sum            = sum + frame[k+1];
            result.mask[k] = |(frame[k+1] & TOP_BIT);
        end
        result.good = fmt_ok && (sum == frame[FRAME_BYTES-1]);

        // First start byte after position 0 sets the bytes kept on a reject
        for (int k = 1; k < FRAME_BYTES; k++) begin
            if (!slid && frame[k] == START_BYTE) begin
                result.slide_fill = 3'(FRAME_BYTES - k);
                slid              = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
